@@ rtl/quoted_argument_tokenizer_assert.svh @@
// assertion macros for the tokenizer
`ifndef QUOTED_ARGUMENT_TOKENIZER_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define QAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication
`define QAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

@@ rtl/qat_pkg.sv @@
`timescale 1ns / 1ps

package qat_pkg;

  localparam int LINE_MAX_DEF  = 256;
  localparam int ARG_LIMIT_DEF = 16;

  localparam logic OP_EOL = 1'b1;

  localparam logic [1:0] K_START = 2'd0;
  localparam logic [1:0] K_BYTE  = 2'd1;
  localparam logic [1:0] K_END   = 2'd2;
  localparam logic [1:0] K_DONE  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LONG = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BS  = 8'h5C;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] index;
    logic [4:0] count;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                  input logic [3:0] index, input logic [4:0] count,
                                  input logic [1:0] status, input logic last);
    res_t r;
    r.kind   = kind;
    r.data   = data;
    r.index  = index;
    r.count  = count;
    r.status = status;
    r.last   = last;
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

@@ rtl/quoted_argument_tokenizer.sv @@
`timescale 1ns / 1ps
// quoted argument tokenizer
// input channel: one item per character (in_op low, in_char_byte) or an
// end-of-line item (in_op high); a zero character is dropped
// result channel: token start, token byte, token end and line done items,
// out_last marks the final result of each input item
// an accepted item waits in the input register, is parsed there
// and its zero, one or two results go into a four-entry result queue
// results are registered in the queue before they are offered
// throughput: one input item per cycle while each item gives at most one
// result and the receiver does not stall; an item with two results puts
// both out at the result port in turn, the queue needs room for two to parse
// receiver stall: the queue fills, then in_stall rises and the input item
// waits in its register; nothing is lost or dropped
// reset: synchronous, active low; clears the queue and returns the parser
// to the between-arguments state with zero count and length
`include "quoted_argument_tokenizer_assert.svh"

module quoted_argument_tokenizer #(
  parameter int LINE_MAX  = qat_pkg::LINE_MAX_DEF,
  parameter int ARG_LIMIT = qat_pkg::ARG_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [3:0] out_token_index,
  output logic [4:0] out_arg_count,
  output logic [1:0] out_status,
  output logic       out_last
);
  import qat_pkg::*;

  push_t            push;
  res_t             res;
  logic [CNT_W-1:0] count;
  logic             room;
  logic             pop;

  assign pop  = out_valid && !out_stall;
  assign room = (count <= CNT_W'(FIFO_DEPTH - 2)) ||
                ((count == CNT_W'(FIFO_DEPTH - 1)) && pop);

  qat_scan #(
    .LINE_MAX  (LINE_MAX),
    .ARG_LIMIT (ARG_LIMIT)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_char_byte (in_char_byte),
    .room         (room),
    .push         (push)
  );

  qat_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .count     (count)
  );

  assign out_kind        = res.kind;
  assign out_byte        = res.data;
  assign out_token_index = res.index;
  assign out_arg_count   = res.count;
  assign out_status      = res.status;
  assign out_last        = res.last;

  `QAT_ASSERT_IMP(a_no_overflow, 1'b1, count <= CNT_W'(FIFO_DEPTH))
  `QAT_ASSERT_IMP(a_pair_order, push.n == 2'd2, !push.r0.last && push.r1.last)
  `QAT_ASSERT_IMP(a_done_last, out_valid && out_kind == K_DONE, out_last)
  `QAT_ASSERT_NXT(a_push_shows, push.n != 2'd0, out_valid)

endmodule

@@ rtl/qat_scan.sv @@
`timescale 1ns / 1ps

module qat_scan #(
  parameter int LINE_MAX  = qat_pkg::LINE_MAX_DEF,
  parameter int ARG_LIMIT = qat_pkg::ARG_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_op,
  input  logic [7:0]      in_char_byte,
  input  logic            room,
  output qat_pkg::push_t  push
);
  import qat_pkg::*;

  localparam int LLW  = $clog2(LINE_MAX + 1);
  localparam int TCR  = $clog2(ARG_LIMIT + 1);
  localparam int TCW  = (TCR > 5) ? TCR : 5;

  typedef enum logic [5:0] {
    M_BETWEEN = 6'b000001,
    M_PLAIN   = 6'b000010,
    M_DQ      = 6'b000100,
    M_DQ_ESC  = 6'b001000,
    M_SQ      = 6'b010000,
    M_ERROR   = 6'b100000
  } mode_t;

  logic           s_vld_r, s_vld_nxt;
  logic           s_op_r;
  logic [7:0]     s_byte_r;
  mode_t          mode_r, mode_nxt;
  logic [TCW-1:0] tc_r, tc_nxt;
  logic [LLW-1:0] ll_r, ll_nxt;
  logic           tl_r, tl_nxt;
  logic           proc;
  logic           take;
  logic [TCW-1:0] tc_dec;
  logic [3:0]     idx_cur;
  logic [3:0]     idx_new;
  logic [1:0]     st;

  assign proc     = s_vld_r && room;
  assign in_stall = s_vld_r && !room;
  assign take     = in_valid && !in_stall;
  assign tc_dec   = tc_r - TCW'(1);
  assign idx_cur  = tc_dec[3:0];
  assign idx_new  = tc_r[3:0];

  always_comb begin
    s_vld_nxt = s_vld_r;
    if (take) begin
      s_vld_nxt = 1'b1;
    end else if (proc) begin
      s_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    tc_nxt   = tc_r;
    ll_nxt   = ll_r;
    tl_nxt   = tl_r;
    push     = '0;
    st       = ST_OK;
    if (tl_r) begin
      st = ST_LONG;
    end else if (mode_r != M_BETWEEN && mode_r != M_PLAIN) begin
      st = ST_ERR;
    end
    if (proc) begin
      if (s_op_r == OP_EOL) begin
        if (!tl_r && mode_r == M_PLAIN) begin
          push.n  = 2'd2;
          push.r0 = mk_res(K_END, 8'h00, idx_cur, 5'd0, ST_OK, 1'b0);
          push.r1 = mk_res(K_DONE, 8'h00, 4'd0, tc_r[4:0], st, 1'b1);
        end else begin
          push.n  = 2'd1;
          push.r0 = mk_res(K_DONE, 8'h00, 4'd0, tc_r[4:0], st, 1'b1);
        end
        mode_nxt = M_BETWEEN;
        tc_nxt   = '0;
        ll_nxt   = '0;
        tl_nxt   = 1'b0;
      end else if (s_byte_r != 8'h00 && !tl_r) begin
        if (ll_r >= LLW'(LINE_MAX - 1)) begin
          ll_nxt = LLW'(LINE_MAX);
          tl_nxt = 1'b1;
        end else begin
          ll_nxt = ll_r + LLW'(1);
          unique case (mode_r)
            M_BETWEEN: begin
              if (!is_blank(s_byte_r)) begin
                if (tc_r >= TCW'(ARG_LIMIT)) begin
                  mode_nxt = M_ERROR;
                end else begin
                  tc_nxt = tc_r + TCW'(1);
                  if (s_byte_r == CH_DQ || s_byte_r == CH_SQ) begin
                    mode_nxt = (s_byte_r == CH_DQ) ? M_DQ : M_SQ;
                    push.n   = 2'd1;
                    push.r0  = mk_res(K_START, 8'h00, idx_new, 5'd0, ST_OK, 1'b1);
                  end else begin
                    mode_nxt = M_PLAIN;
                    push.n   = 2'd2;
                    push.r0  = mk_res(K_START, 8'h00, idx_new, 5'd0, ST_OK, 1'b0);
                    push.r1  = mk_res(K_BYTE, s_byte_r, idx_new, 5'd0, ST_OK, 1'b1);
                  end
                end
              end
            end
            M_PLAIN: begin
              push.n = 2'd1;
              if (is_blank(s_byte_r)) begin
                mode_nxt = M_BETWEEN;
                push.r0  = mk_res(K_END, 8'h00, idx_cur, 5'd0, ST_OK, 1'b1);
              end else begin
                push.r0  = mk_res(K_BYTE, s_byte_r, idx_cur, 5'd0, ST_OK, 1'b1);
              end
            end
            M_DQ: begin
              if (s_byte_r == CH_DQ) begin
                mode_nxt = M_BETWEEN;
                push.n   = 2'd1;
                push.r0  = mk_res(K_END, 8'h00, idx_cur, 5'd0, ST_OK, 1'b1);
              end else if (s_byte_r == CH_BS) begin
                mode_nxt = M_DQ_ESC;
              end else begin
                push.n   = 2'd1;
                push.r0  = mk_res(K_BYTE, s_byte_r, idx_cur, 5'd0, ST_OK, 1'b1);
              end
            end
            M_DQ_ESC: begin
              mode_nxt = M_DQ;
              push.n   = 2'd1;
              push.r0  = mk_res(K_BYTE, s_byte_r, idx_cur, 5'd0, ST_OK, 1'b1);
            end
            M_SQ: begin
              push.n = 2'd1;
              if (s_byte_r == CH_SQ) begin
                mode_nxt = M_BETWEEN;
                push.r0  = mk_res(K_END, 8'h00, idx_cur, 5'd0, ST_OK, 1'b1);
              end else begin
                push.r0  = mk_res(K_BYTE, s_byte_r, idx_cur, 5'd0, ST_OK, 1'b1);
              end
            end
            M_ERROR: begin
              mode_nxt = M_ERROR;
            end
            default: begin
              mode_nxt = M_ERROR;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      mode_r  <= M_BETWEEN;
      tc_r    <= '0;
      ll_r    <= '0;
      tl_r    <= 1'b0;
    end else begin
      s_vld_r <= s_vld_nxt;
      mode_r  <= mode_nxt;
      tc_r    <= tc_nxt;
      ll_r    <= ll_nxt;
      tl_r    <= tl_nxt;
    end
  end

  // input item register, payload only
  always_ff @(posedge clk) begin
    if (take) begin
      s_op_r   <= in_op;
      s_byte_r <= in_char_byte;
    end
  end

endmodule

@@ rtl/qat_res_fifo.sv @@
`timescale 1ns / 1ps

module qat_res_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qat_pkg::push_t             push,
  output logic                       out_valid,
  input  logic                       out_stall,
  output qat_pkg::res_t              out_res,
  output logic [qat_pkg::CNT_W-1:0]  count
);
  import qat_pkg::*;

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rp_r];
  assign count     = cnt_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wp_nxt  = wp_r + PTR_W'(push.n);
    rp_nxt  = rp_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(push.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wp_r + PTR_W'(1)] <= push.r1;
    end
  end

endmodule
